[rtl/uekg_pkg.sv]
// ============================================================================
// uekg_pkg: shared types and constants of the echo range and Kalman guard
// Widths of the register fields, reset values, register indexes, action codes
// and the result record of the serial divider.
// ============================================================================
package uekg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register field widths
    localparam int TMO_W  = 20;
    localparam int THR_W  = 9;
    localparam int COEF_W = 20;
    localparam int PN_W   = 16;
    localparam int MN_W   = 18;

    // Kalman arithmetic widths (Q2.16)
    localparam int FRAC_W = 16;
    localparam int P_W    = 18;
    localparam int DEN_W  = 19;
    localparam int GAIN_W = 17;
    localparam int REM_W  = 20;

    // shared multiplier: A side carries pulse width or gain terms
    localparam int MUL_A_W = 20;

    // result field widths
    localparam int OUT_DIST_W = 17;
    localparam int ACT_W      = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PNOISE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MNOISE    = 3'd4;

    // reset values
    localparam logic [TMO_W-1:0]  TMO_RST  = 20'd26100;
    localparam logic [THR_W-1:0]  THR_RST  = 9'd20;
    localparam logic [COEF_W-1:0] COEF_RST = 20'd287729;
    localparam logic [PN_W-1:0]   PN_RST   = 16'd655;
    localparam logic [MN_W-1:0]   MN_RST   = 18'd32768;
    localparam logic [P_W-1:0]    P_RST    = 18'd65536;

    // 1.0 in Q16
    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE   = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_RESUME = 2'd2
    } t_action;

    // divider result: done pulse and quotient
    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quot;
    } t_div_res;

endpackage

[rtl/ultrasonic_echo_kalman_guard_top.sv]
// ============================================================================
// ultrasonic_echo_kalman_guard_top: echo range with Kalman smoothing and guard
// Echo edge timestamps in; one range result per falling edge out.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall): one echo edge per transfer.
//   A rising edge (i_cmd = 0) stores its timestamp and makes no
//   result. A falling edge measures the pulse and makes one result.
//   Output channel (o_out_valid / i_out_stall): one result per transfer,
//   held in an output register until taken.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while the block is idle.
// Flow:
//   A falling edge runs the serial gain divider (17 quotient bits, one a
//   cycle) before the estimate and variance updates. A timed-out pulse
//   skips them. The input is stalled while an edge is at work, so a new
//   falling edge is taken only once the last result has left the sequencer;
//   rising edges are taken one per cycle while the block is idle.
//   The shared multiplier handles range, estimate and variance updates.
// Reset: synchronous, active low; registers return to their defaults,
//   estimate 0, variance 1.0, not blocked.
// Stall: a finished result waits in the sequencer until the output register
//   is free; the register itself holds while i_out_stall is high.
// ============================================================================
module ultrasonic_echo_kalman_guard_top #(
    parameter int TIME_BITS = 32,
    parameter int DIST_BITS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // edge input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_time_us,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_timed_out,
    output logic [16:0] o_raw_distance,
    output logic [16:0] o_filtered_distance,
    output logic        o_blocked,
    output logic [1:0]  o_action,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import uekg_pkg::*;

    localparam int MUL_B_W = (DIST_BITS > COEF_W) ? DIST_BITS : COEF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int HI_W    = PROD_W - FRAC_W;
    localparam int TW      = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;
    localparam int CW      = (DIST_BITS > OUT_DIST_W) ? DIST_BITS : OUT_DIST_W;
    localparam logic [HI_W-1:0] DIST_MAX_HI =
        {{(HI_W - DIST_BITS){1'b0}}, {DIST_BITS{1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RAW,
        S_DIV,
        S_MAG,
        S_EST,
        S_VAR,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [TMO_W-1:0]  r_timeout;
    logic [THR_W-1:0]  r_thr;
    logic [COEF_W-1:0] r_coef;
    logic [PN_W-1:0]   r_pn;
    logic [MN_W-1:0]   r_mn;

    // block state
    logic [TIME_BITS-1:0] r_start;
    logic [DIST_BITS-1:0] r_est;
    logic [P_W-1:0]       r_var;
    logic                 r_flag;

    // per-edge working registers
    logic [TIME_BITS-1:0] r_t;
    logic [TMO_W-1:0]     r_width;
    logic                 r_tmo;
    logic [P_W-1:0]       r_p1;
    logic [DIST_BITS-1:0] r_raw;
    logic [GAIN_W-1:0]    r_gain;
    logic [DIST_BITS-1:0] r_diff;
    logic                 r_neg;

    // finished result
    logic                 r_res_tmo;
    logic [DIST_BITS-1:0] r_res_raw;
    logic [DIST_BITS-1:0] r_res_filt;
    logic                 r_res_blk;
    t_action              r_res_act;

    // output register
    logic                  r_out_valid;
    logic                  r_o_tmo;
    logic [OUT_DIST_W-1:0] r_o_raw;
    logic [OUT_DIST_W-1:0] r_o_filt;
    logic                  r_o_blk;
    t_action               r_o_act;

    // combinational signals
    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] width_full;
    logic [TW-1:0]        width_ext;
    logic                 over;
    logic [P_W:0]         p1_sum;
    logic [P_W-1:0]       p1_sat;
    logic [DEN_W-1:0]     den;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    w_prod;
    logic [HI_W-1:0]      prod_hi;
    logic [DIST_BITS-1:0] raw_sat;
    logic [DIST_BITS-1:0] mag;
    logic [DIST_BITS-1:0] est_new;
    logic [P_W-1:0]       var_new;
    logic [OUT_DIST_W-1:0] thr_q8;
    logic                 hit;
    logic                 out_free;
    logic [CW-1:0]        raw_ext;
    logic [CW-1:0]        filt_ext;
    t_div_res             div_res;

    // pulse width and timeout compare
    always_comb begin
        t_in       = TIME_BITS'(i_time_us);
        width_full = t_in - r_start;
        width_ext  = TW'(width_full);
        over       = width_ext > TW'(r_timeout);
    end

    // predicted variance and gain divisor
    always_comb begin
        p1_sum = {1'b0, r_var} + (P_W + 1)'(r_pn);
        p1_sat = p1_sum[P_W] ? '1 : p1_sum[P_W-1:0];
        den    = DEN_W'(r_p1) + DEN_W'(r_mn);
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MAG: begin
                mul_a = MUL_A_W'(r_gain);
                mul_b = MUL_B_W'(r_diff);
            end
            S_EST: begin
                mul_a = MUL_A_W'(ONE_Q16 - r_gain);
                mul_b = MUL_B_W'(r_p1);
            end
            default: begin
                mul_a = r_width;
                mul_b = MUL_B_W'(r_coef);
            end
        endcase
    end

    uekg_mul #(
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (w_prod)
    );

    uekg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RAW),
        .i_num   (r_p1),
        .i_den   (den),
        .o_res   (div_res)
    );

    // product post-processing
    always_comb begin
        prod_hi  = w_prod[PROD_W-1:FRAC_W];
        raw_sat  = (prod_hi > DIST_MAX_HI) ? '1 : prod_hi[DIST_BITS-1:0];
        mag      = prod_hi[DIST_BITS-1:0];
        est_new  = r_neg ? (r_est - mag) : (r_est + mag);
        var_new  = w_prod[FRAC_W+P_W-1:FRAC_W];
        thr_q8   = {r_thr, 8'h00};
        hit      = CW'(r_est) <= CW'(thr_q8);
        out_free = !r_out_valid || !i_out_stall;
        raw_ext  = CW'(r_res_raw);
        filt_ext = CW'(r_res_filt);
    end

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_timeout   <= TMO_RST;
            r_thr       <= THR_RST;
            r_coef      <= COEF_RST;
            r_pn        <= PN_RST;
            r_mn        <= MN_RST;
            r_start     <= '0;
            r_est       <= '0;
            r_var       <= P_RST;
            r_flag      <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT:   r_timeout <= i_cfg_data[TMO_W-1:0];
                    CFG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                    CFG_RANGE:     r_coef    <= i_cfg_data[COEF_W-1:0];
                    CFG_PNOISE:    r_pn      <= i_cfg_data[PN_W-1:0];
                    CFG_MNOISE:    r_mn      <= i_cfg_data[MN_W-1:0];
                    default: ;
                endcase
            end

            // a finished result fills the register, an output transfer frees it
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!i_cmd) begin
                            r_start <= t_in;
                        end else begin
                            r_t     <= t_in;
                            r_width <= width_ext[TMO_W-1:0];
                            r_tmo   <= over;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_p1 <= p1_sat;
                    if (r_tmo) begin
                        r_start    <= r_t;
                        r_res_tmo  <= 1'b1;
                        r_res_raw  <= '0;
                        r_res_filt <= r_est;
                        r_res_blk  <= r_flag;
                        r_res_act  <= ACT_NONE;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_RAW;
                    end
                end
                S_RAW: begin
                    r_raw   <= raw_sat;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_neg  <= r_raw < r_est;
                    r_diff <= (r_raw < r_est) ? (r_est - r_raw) : (r_raw - r_est);
                    if (div_res.done) begin
                        r_gain  <= div_res.quot;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_state <= S_EST;
                end
                S_EST: begin
                    r_est   <= est_new;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_var      <= var_new;
                    r_res_tmo  <= 1'b0;
                    r_res_raw  <= r_raw;
                    r_res_filt <= r_est;
                    // hysteresis on the smoothed distance
                    if (hit && !r_flag) begin
                        r_flag    <= 1'b1;
                        r_res_blk <= 1'b1;
                        r_res_act <= ACT_STOP;
                    end else if (!hit && r_flag) begin
                        r_flag    <= 1'b0;
                        r_res_blk <= 1'b0;
                        r_res_act <= ACT_RESUME;
                    end else begin
                        r_res_blk <= r_flag;
                        r_res_act <= ACT_NONE;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_tmo     <= r_res_tmo;
                        r_o_raw     <= raw_ext[OUT_DIST_W-1:0];
                        r_o_filt    <= filt_ext[OUT_DIST_W-1:0];
                        r_o_blk     <= r_res_blk;
                        r_o_act     <= r_res_act;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_timed_out         = r_o_tmo;
    assign o_raw_distance      = r_o_raw;
    assign o_filtered_distance = r_o_filt;
    assign o_blocked           = r_o_blk;
    assign o_action            = r_o_act;

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // gain never exceeds 1.0
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAG) |-> (r_gain <= ONE_Q16))
        else $error("Kalman gain above 1.0");

    // correction never overshoots the measurement
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EST) |-> (mag <= r_diff))
        else $error("estimate correction larger than innovation");

    // timed-out results carry no action
    a_tmo_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_action == ACT_NONE))
        else $error("action on timed-out result");

    // action agrees with the reported flag
    a_action_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_STOP || o_action == ACT_RESUME))
            |-> (o_blocked == (o_action == ACT_STOP)))
        else $error("action disagrees with blocked flag");

endmodule

[rtl/uekg_div.sv]
// ============================================================================
// uekg_div: serial restoring divider for the Kalman gain
// Computes floor(num * 2^16 / den), one quotient bit per cycle.
// A zero divisor gives a zero quotient.
// ============================================================================
module uekg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [uekg_pkg::P_W-1:0]     i_num,
    input  logic [uekg_pkg::DEN_W-1:0]   i_den,
    output uekg_pkg::t_div_res           o_res
);
    import uekg_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [GAIN_W-1:0] r_q;

    logic             ge;
    logic [REM_W-1:0] rem_sub;
    logic [REM_W-1:0] rem_next;

    // one compare and subtract per cycle
    always_comb begin
        ge       = r_rem >= REM_W'(r_den);
        rem_sub  = ge ? (r_rem - REM_W'(r_den)) : r_rem;
        rem_next = {rem_sub[REM_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= REM_W'(i_num);
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= rem_next;
                r_q   <= {r_q[GAIN_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = (r_den == '0) ? '0 : r_q;

endmodule

[rtl/uekg_mul.sv]
// ============================================================================
// uekg_mul: shared registered multiplier
// Unsigned A x B with the product registered.
// ============================================================================
module uekg_mul #(
    parameter int B_W = 20
) (
    input  logic                                i_clk,
    input  logic [uekg_pkg::MUL_A_W-1:0]        i_a,
    input  logic [B_W-1:0]                      i_b,
    output logic [uekg_pkg::MUL_A_W+B_W-1:0]    o_prod
);
    import uekg_pkg::*;

    localparam int PROD_W = MUL_A_W + B_W;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top: echo range, Kalman smoothing and obstacle guard testbench
// Drives timestamped echo edges with random gaps and result stalls, predicts
// every range result with a bit-exact fixed-point tracker kept in step with
// the register writes, and checks each result transfer against it.
// ============================================================================
module tb_top;
    import uekg_pkg::*;

    // edge kinds on i_cmd
    localparam logic EDGE_RISE = 1'b0;
    localparam logic EDGE_FALL = 1'b1;

    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer at all
    localparam int DRAIN_WAIT  = 32;    // falling edge latency plus margin
    localparam int MAX_PAUSE   = 11;

    typedef struct {
        logic        cmd;
        logic [31:0] stamp;
        int          pause;
    } t_echo_edge;

    typedef struct packed {
        logic                  timed_out;
        logic [OUT_DIST_W-1:0] raw;
        logic [OUT_DIST_W-1:0] filt;
        logic                  blocked;
        t_action               act;
    } t_range_result;

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_cmd    = EDGE_RISE;
    logic [31:0] in_time   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  timed_out;
    logic [OUT_DIST_W-1:0] raw_dist;
    logic [OUT_DIST_W-1:0] filt_dist;
    logic                  blocked;
    logic [ACT_W-1:0]      action;
    logic                  cfg_ready;

    // tracker registers and state
    logic [TMO_W-1:0]      tmo_m  = TMO_RST;
    logic [THR_W-1:0]      thr_m  = THR_RST;
    logic [COEF_W-1:0]     coef_m = COEF_RST;
    logic [PN_W-1:0]       pn_m   = PN_RST;
    logic [MN_W-1:0]       mn_m   = MN_RST;
    logic [31:0]           echo_t0   = '0;
    logic [OUT_DIST_W-1:0] dist_est  = '0;
    logic [P_W-1:0]        var_p     = P_RST;
    logic                  blocked_m = 1'b0;

    t_echo_edge    edges_todo[$];
    t_range_result ranges_due[$];

    logic calm = 1'b0;
    int n_pushed   = 0;
    int n_sent     = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_timeouts = 0;
    int n_stops    = 0;
    int n_resumes  = 0;
    int n_settings = 1;
    int quiet      = 0;

    ultrasonic_echo_kalman_guard_top i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_cmd               (in_cmd),
        .i_time_us           (in_time),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_timed_out         (timed_out),
        .o_raw_distance      (raw_dist),
        .o_filtered_distance (filt_dist),
        .o_blocked           (blocked),
        .o_action            (action),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle cycles before an item or result; none at all in calm phases
    function automatic int draw_pause();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_PAUSE);
    endfunction

    // advance the tracker by one echo edge, queue the result it causes
    function automatic void range_track(input logic cmd, input logic [31:0] stamp);
        logic [31:0]           width;
        logic [39:0]           prod;
        logic [OUT_DIST_W-1:0] raw;
        logic [18:0]           p1;
        logic [19:0]           den;
        logic [34:0]           quot;
        logic [GAIN_W-1:0]     gain;
        logic [33:0]           mag;
        logic [34:0]           pvar;
        logic [OUT_DIST_W-1:0] thr_q8;
        t_range_result         res;

        if (cmd == EDGE_RISE) begin
            echo_t0 = stamp;
            return;
        end
        width = stamp - echo_t0;
        if (width > {12'd0, tmo_m}) begin
            // timed out: restart from this edge, estimate and flag untouched
            echo_t0       = stamp;
            res.timed_out = 1'b1;
            res.raw       = '0;
            res.filt      = dist_est;
            res.blocked   = blocked_m;
            res.act       = ACT_NONE;
            ranges_due.push_back(res);
            return;
        end
        // range in Q.8, saturated
        prod = width[19:0] * coef_m;
        raw  = (prod[39:16] > 24'h01FFFF) ? 17'h1FFFF : prod[32:16];
        // predict, gain, correct
        p1 = var_p + pn_m;
        if (p1 > 19'h3FFFF)
            p1 = 19'h3FFFF;
        den  = p1 + mn_m;
        quot = (den == 0) ? 35'd0 : {p1, 16'h0000} / den;
        gain = quot[16:0];
        if (raw >= dist_est) begin
            mag      = gain * (raw - dist_est);
            dist_est = dist_est + mag[32:16];
        end else begin
            mag      = gain * (dist_est - raw);
            dist_est = dist_est - mag[32:16];
        end
        pvar  = (ONE_Q16 - gain) * p1;
        var_p = pvar[33:16];
        // hysteresis guard
        thr_q8  = {thr_m, 8'h00};
        res.act = ACT_NONE;
        if (dist_est <= thr_q8 && !blocked_m) begin
            blocked_m = 1'b1;
            res.act   = ACT_STOP;
        end else if (dist_est > thr_q8 && blocked_m) begin
            blocked_m = 1'b0;
            res.act   = ACT_RESUME;
        end
        res.timed_out = 1'b0;
        res.raw       = raw;
        res.filt      = dist_est;
        res.blocked   = blocked_m;
        ranges_due.push_back(res);
    endfunction

    task automatic push_edge(input logic cmd, input logic [31:0] stamp);
        t_echo_edge e;
        e.cmd   = cmd;
        e.stamp = stamp;
        e.pause = draw_pause();
        edges_todo.push_back(e);
        n_pushed++;
    endtask

    task automatic push_pulse(input logic [31:0] start, input logic [31:0] width);
        push_edge(EDGE_RISE, start);
        push_edge(EDGE_FALL, start + width);
    endtask

    // one register write; valid stays up for a following write
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TIMEOUT:   tmo_m  = val;
            CFG_THRESHOLD: thr_m  = val[THR_W-1:0];
            CFG_RANGE:     coef_m = val;
            CFG_PNOISE:    pn_m   = val[PN_W-1:0];
            CFG_MNOISE:    mn_m   = val[MN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [TMO_W-1:0] tmo, input logic [THR_W-1:0] thr,
                                  input logic [COEF_W-1:0] coef, input logic [PN_W-1:0] pn,
                                  input logic [MN_W-1:0] mn);
        set_reg(CFG_TIMEOUT, tmo);
        set_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        set_reg(CFG_RANGE, coef);
        set_reg(CFG_PNOISE, CFG_DATA_W'(pn));
        set_reg(CFG_MNOISE, CFG_DATA_W'(mn));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // wait until every edge is taken and every result checked, then let
    // a rising edge still in flight finish
    task automatic settle();
        while (n_sent != n_pushed || ranges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // mostly complete pulses aimed around the threshold and the timeout,
    // with lone falling edges and repeated rising edges mixed in
    task automatic random_phase(input int n_items);
        longint unsigned near;
        longint unsigned thr64;
        logic [31:0]     t0;
        logic [31:0]     w;
        int              kind;
        int              shape;
        int              target;

        target = n_pushed + n_items;
        thr64  = thr_m;
        near   = (coef_m == 0) ? 1000 : (thr64 << 24) / coef_m;
        if (near > 1048575)
            near = 1048575;
        while (n_pushed < target) begin
            if ($urandom_range(0, 3) == 0)
                t0 = 32'hFFFF_FFFF - $urandom_range(0, 4000);
            else
                t0 = $urandom;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: w = $urandom_range(0, 32'(2 * near + 16));
                3, 4:    w = $urandom_range(0, tmo_m);
                5:       w = $urandom_range(0, 64);
                6:       w = tmo_m + $urandom_range(0, 1);
                7:       w = tmo_m + 2 + $urandom_range(0, 500);
                default: w = $urandom;
            endcase
            if (kind <= 5 && w > tmo_m)
                w = tmo_m;
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                push_edge(EDGE_FALL, t0 + w);
            end else if (shape == 1) begin
                push_edge(EDGE_RISE, t0 - $urandom_range(0, 5000));
                push_pulse(t0, w);
            end else begin
                push_pulse(t0, w);
            end
        end
    endtask

    // reset, directed edges, then random phases under several settings
    initial begin : stimulus
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default settings: falling edge with no rising edge before it
        push_edge(EDGE_FALL, 32'd100);
        push_pulse(32'd1000, 32'd0);
        // timestamp wraps inside the pulse
        push_pulse(32'hFFFF_FF00, 32'd768);
        // repeated rising edges, the later one counts
        push_edge(EDGE_RISE, 32'd5000);
        push_pulse(32'd6000, 32'd500);
        // exactly the timeout, then one past it, then a falling edge
        // measured from the timed-out edge
        push_pulse(32'd7000, 32'd26100);
        push_pulse(32'd40000, 32'd26101);
        push_edge(EDGE_FALL, 32'd66701);
        // close echoes pull the estimate under the threshold, far ones lift it
        push_pulse(32'd100000, 32'd300);
        push_pulse(32'd200000, 32'd300);
        push_pulse(32'd300000, 32'd300);
        push_pulse(32'd400000, 32'd20000);
        push_pulse(32'd500000, 32'd20000);
        settle();

        // every register at its maximum: saturated range, all-ones timestamp
        apply_settings(20'hFFFFF, 9'h1FF, 20'hFFFFF, 16'hFFFF, 18'h3FFFF);
        push_pulse(32'd0, 32'h000F_FFFF);
        push_edge(EDGE_FALL, 32'hFFFF_FFFF);
        settle();

        for (k = 0; k < 8; k++) begin
            case (k)
                0: apply_settings(TMO_RST, THR_RST, COEF_RST, PN_RST, MN_RST);
                1: apply_settings('0, '0, '0, '0, 18'd1);
                // no process noise and tiny R drive the variance to zero
                3: apply_settings(20'd30000, THR_W'($urandom_range(0, 511)),
                                  COEF_RST, '0, 18'd1);
                4: apply_settings(20'hFFFFF, 9'h1FF, 20'hFFFFF, 16'hFFFF, 18'h3FFFF);
                default: apply_settings(TMO_W'($urandom), THR_W'($urandom),
                                        COEF_W'($urandom), PN_W'($urandom),
                                        MN_W'($urandom_range(1, 262143)));
            endcase
            calm = (k == 2 || k == 5);
            random_phase(78);
            settle();
        end

        if (ranges_due.size() != 0)
            n_errors += ranges_due.size();
        $display("covered %0d echo edges and %0d range results under %0d settings",
                 n_sent, n_results, n_settings);
        $display("results seen: %0d timeouts, %0d stop and %0d resume actions",
                 n_timeouts, n_stops, n_resumes);
        if (n_errors == 0)
            $display("ultrasonic_echo_kalman_guard_top test passed");
        else
            $display("ultrasonic_echo_kalman_guard_top test failed");
        $finish;
    end

    // edge driver: predicts on each transfer, then presents the next edge
    always @(posedge clk) begin : edge_driver
        t_echo_edge nxt;
        int         waited;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                range_track(in_cmd, in_time);
                n_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (edges_todo.size() != 0 && waited < edges_todo[0].pause) begin
                    waited++;
                    in_valid <= 1'b0;
                end else if (edges_todo.size() != 0) begin
                    nxt      = edges_todo.pop_front();
                    waited   = 0;
                    in_valid <= 1'b1;
                    in_cmd   <= nxt.cmd;
                    in_time  <= nxt.stamp;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each transfer with the oldest prediction,
    // then stall the next result for a drawn number of valid cycles
    always @(posedge clk) begin : result_monitor
        t_range_result want;
        int            hold;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (ranges_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: to=%0b raw=%0h filt=%0h blk=%0b act=%0d",
                                 timed_out, raw_dist, filt_dist, blocked, action);
                end else begin
                    want = ranges_due.pop_front();
                    n_timeouts += want.timed_out;
                    n_stops    += (want.act == ACT_STOP);
                    n_resumes  += (want.act == ACT_RESUME);
                    if (timed_out !== want.timed_out || raw_dist !== want.raw ||
                        filt_dist !== want.filt || blocked !== want.blocked ||
                        action !== want.act) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"result %0d mismatch: expected to=%0b raw=%0h filt=%0h",
                                      " blk=%0b act=%0d, got to=%0b raw=%0h filt=%0h",
                                      " blk=%0b act=%0d"},
                                     n_results, want.timed_out, want.raw, want.filt,
                                     want.blocked, want.act, timed_out, raw_dist,
                                     filt_dist, blocked, action);
                    end
                end
                hold = draw_pause();
            end else if (out_valid && hold > 0) begin
                hold--;
            end
            out_stall <= (hold != 0);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("ultrasonic_echo_kalman_guard_top test failed");
            $finish;
        end
    end

endmodule

[ultrasonic_echo_kalman_guard_top.f]
rtl/uekg_pkg.sv
rtl/uekg_div.sv
rtl/uekg_mul.sv
rtl/ultrasonic_echo_kalman_guard_top.sv
dv/tb_top.sv
